// ===== src/fdsf_pkg.sv =====
package fdsf_pkg;

  // Frame limits
  localparam int unsigned MaxWidth  = 512;
  localparam int unsigned MaxHeight = 512;

  // Pixel word layout
  localparam int unsigned Lanes   = 4;
  localparam int unsigned PixW    = 8;
  localparam int unsigned WordW   = Lanes * PixW;
  localparam int unsigned LaneIdW = $clog2(Lanes);

  // Register and position widths
  localparam int unsigned RegW   = 10;
  localparam int unsigned ColW   = 9;
  localparam int unsigned RowW   = 9;
  localparam int unsigned WColW  = 7;
  localparam int unsigned WCntW  = WColW + 1;
  localparam int unsigned CfgIdxW = 1;

  // Stream widths
  localparam int unsigned InDataW  = 2 * WordW;
  localparam int unsigned OutDataW = 32;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } fdsf_reg_e;

  // Merged lane result for one word
  typedef struct packed {
    logic               any;
    logic [LaneIdW-1:0] first;
    logic [LaneIdW-1:0] last;
  } fdsf_hit_t;

  // Saturate a register value to 1..hi
  function automatic logic [RegW-1:0] clamp_dim(input logic [RegW-1:0] v,
                                                input logic [RegW-1:0] hi);
    logic [RegW-1:0] r;
    if (v == '0) begin
      r = RegW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== src/fdsf_lane.sv =====
module fdsf_lane
  import fdsf_pkg::*;
(
  input  logic [PixW-1:0] new_pix_i,
  input  logic [PixW-1:0] old_pix_i,
  input  logic [RegW-1:0] column_i,
  input  logic [RegW-1:0] width_i,
  output logic            diff_o
);

  // Padding columns past the visible width count as equal
  assign diff_o = (column_i < width_i) && (new_pix_i != old_pix_i);

endmodule

// ===== src/fdsf_merge.sv =====
module fdsf_merge
  import fdsf_pkg::*;
(
  input  logic [Lanes-1:0] diff_i,
  output fdsf_hit_t        hit_o
);

  // Lowest and highest differing lane
  always_comb begin
    hit_o.any   = |diff_i;
    hit_o.first = '0;
    hit_o.last  = '0;
    for (int k = Lanes - 1; k >= 0; k--) begin
      if (diff_i[k]) begin
        hit_o.first = LaneIdW'(k);
      end
    end
    for (int k = 0; k < Lanes; k++) begin
      if (diff_i[k]) begin
        hit_o.last = LaneIdW'(k);
      end
    end
  end

endmodule

// ===== src/frame_diff_span_finder_top.sv =====
// Frame difference span finder.
// Input stream: one transfer per 32-bit word pair, new frame pixels in
// tdata[31:0] and previous frame pixels in tdata[63:32], row-major order,
// pixel 4w+k of a row in byte k. A row takes ceil(frame_width/4) words.
// Output stream: one transfer per closed span (tuser = 1) with row, first
// and last column; tlast marks the result of the frame's last word, which
// is sent even when no span closes there (tuser = 0, fields zero).
// Config channel: index 0 writes frame_width, index 1 frame_height; values
// saturate to 1..512. Write only while the streams are idle.
// A result is registered and appears on the output in the cycle after the
// word that closes it is transferred. Input: one word per cycle when not
// stalled; the four byte lanes compare in parallel and the span tracker
// updates on each accepted word. A single output register holds the
// pending result; input is taken whenever that register is empty or is
// being drained the same cycle, so a stalled receiver backs up into
// s_axis_tready after one result. Reset clears the position, any open
// span and the output register, and restores width 320 and height 240.
module frame_diff_span_finder_top
  import fdsf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input words
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InDataW-1:0]   s_axis_tdata_i,   // new_pixels[31:0], old_pixels[63:32]
  // Span results
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutDataW-1:0]  m_axis_tdata_o,   // span_row[8:0], span_first[17:9],
                                                 // span_last[26:18], zero pad
  output logic                 m_axis_tuser_o,   // span_valid[0]
  output logic                 m_axis_tlast_o,   // frame_done
  // Configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [RegW-1:0]      cfg_data_i
);

  localparam logic [RegW-1:0] WidthReset  = RegW'(320);
  localparam logic [RegW-1:0] HeightReset = RegW'(240);
  localparam logic [RegW-1:0] WidthMax    = RegW'(MaxWidth);
  localparam logic [RegW-1:0] HeightMax   = RegW'(MaxHeight);

  logic [RegW-1:0]  width_q, height_q;
  logic [WColW-1:0] wcol_q, wcol_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             open_q, open_d;
  logic [ColW-1:0]  open_first_q, open_first_d;
  logic [ColW-1:0]  open_last_q, open_last_d;

  logic             out_valid_q;
  logic [RowW-1:0]  out_row_q;
  logic [ColW-1:0]  out_first_q, out_last_q;
  logic             out_span_q, out_done_q;

  logic [RegW-1:0]  width_c, height_c;
  logic [WCntW-1:0] words_c;
  logic [ColW-1:0]  base;
  logic [Lanes-1:0] diff;
  fdsf_hit_t        hit;
  logic             in_xfer, row_end, frame_end, emit;
  logic [WCntW-1:0] wcol_inc;
  logic [RegW-1:0]  row_inc;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      case (fdsf_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry
  assign width_c  = clamp_dim(width_q, WidthMax);
  assign height_c = clamp_dim(height_q, HeightMax);
  assign words_c  = WCntW'((11'(width_c) + 11'd3) >> 2);
  assign base     = {wcol_q, 2'b00};

  // Byte lanes
  for (genvar k = 0; k < Lanes; k++) begin : g_lane
    fdsf_lane u_lane (
      .new_pix_i (s_axis_tdata_i[k*PixW +: PixW]),
      .old_pix_i (s_axis_tdata_i[WordW + k*PixW +: PixW]),
      .column_i  (RegW'(base) + RegW'(k)),
      .width_i   (width_c),
      .diff_o    (diff[k])
    );
  end

  fdsf_merge u_merge (
    .diff_i (diff),
    .hit_o  (hit)
  );

  // Handshake
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // Position tracking
  assign wcol_inc  = WCntW'(wcol_q) + WCntW'(1);
  assign row_inc   = RegW'(row_q) + RegW'(1);
  assign row_end   = wcol_inc >= words_c;
  assign frame_end = row_end && (row_inc >= height_c);

  // Span tracking
  always_comb begin
    open_d       = open_q;
    open_first_d = open_first_q;
    open_last_d  = open_last_q;
    emit         = 1'b0;
    if (hit.any) begin
      if (!open_q) begin
        open_d       = 1'b1;
        open_first_d = base | ColW'(hit.first);
      end
      open_last_d = base | ColW'(hit.last);
    end else if (open_q) begin
      emit = 1'b1;
    end
    if (row_end && open_d) begin
      emit = 1'b1;
    end
    if (emit) begin
      open_d = 1'b0;
    end
    wcol_d = row_end ? '0 : wcol_inc[WColW-1:0];
    row_d  = row_end ? (frame_end ? '0 : row_inc[RowW-1:0]) : row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q       <= '0;
      row_q        <= '0;
      open_q       <= 1'b0;
      open_first_q <= '0;
      open_last_q  <= '0;
    end else if (in_xfer) begin
      wcol_q       <= wcol_d;
      row_q        <= row_d;
      open_q       <= open_d;
      open_first_q <= open_first_d;
      open_last_q  <= open_last_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= emit || frame_end;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_row_q   <= emit ? row_q : '0;
      out_first_q <= emit ? open_first_d : '0;
      out_last_q  <= emit ? open_last_d : '0;
      out_span_q  <= emit;
      out_done_q  <= frame_end;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'({out_last_q, out_first_q, out_row_q});
  assign m_axis_tuser_o  = out_span_q;
  assign m_axis_tlast_o  = out_done_q;

endmodule
